@@ src/lrbe_pkg.sv @@
// lrbe_pkg: shared constants, codes and the result flag group for the
// lidar ring binning engine. No dependencies.
package lrbe_pkg;

  localparam int MaxRingsDef   = 128;
  localparam int MaxColumnsDef = 4096;
  localparam int MinRings      = 16;
  localparam int ColumnStep    = 512;
  localparam int ColumnRound   = 511;

  localparam int ChanW      = 16;
  localparam int PayW       = 64;
  localparam int NumWords   = 4;
  localparam int AddrW      = 19;
  localparam int RingCountW = 8;
  localparam int PprW       = 13;

  typedef enum logic [1:0] {
    FuncEstimate = 2'd0,
    FuncFinish   = 2'd1,
    FuncPlace    = 2'd2,
    FuncEndFrame = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KindPlaced = 2'd0,
    KindSizes  = 2'd1,
    KindFrame  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  ring_ovf;
    logic  col_ovf;
    logic  frame_ok;
    logic  size_lim;
  } res_flags_t;

endpackage

@@ src/lrbe_ram.sv @@
// lrbe_ram: one-write one-read table with registered read, write bypass and
// per-entry valid bits; an entry that is not valid reads as zero.
// Depends on nothing.
module lrbe_ram #(
  parameter  int Depth = 128,
  parameter  int Width = 13,
  localparam int AW    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             clr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_q;
  logic [Width-1:0] byp_q;
  logic             hit_q;
  logic             rvld_q;
  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] vld_d;

  always_comb begin
    vld_d = vld_q;
    if (clr_i) begin
      vld_d = '0;
    end else if (we_i) begin
      vld_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem_q[raddr_i];
      byp_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      hit_q  <= 1'b0;
      rvld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (rd_en_i) begin
        hit_q  <= we_i && (waddr_i == raddr_i);
        rvld_q <= vld_d[raddr_i];
      end
    end
  end

  assign rdata_o = !rvld_q ? '0 : (hit_q ? byp_q : rd_q);

endmodule

@@ src/lrbe_step.sv @@
// lrbe_step: per-item logic and frame state (sizes, largest channel/count,
// overflow). Drives the histogram and column counter tables. Uses lrbe_pkg.
module lrbe_step #(
  parameter  int MaxRings   = lrbe_pkg::MaxRingsDef,
  parameter  int MaxColumns = lrbe_pkg::MaxColumnsDef,
  localparam int RIdxW      = $clog2(MaxRings),
  localparam int CntW       = $clog2(2 * MaxColumns)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  lrbe_pkg::func_e                 func_i,
  input  logic [lrbe_pkg::ChanW-1:0]      channel_i,
  input  logic [CntW-1:0]                 hist_rd_i,
  input  logic [CntW-1:0]                 cnt_rd_i,
  output logic                            hist_we_o,
  output logic [RIdxW-1:0]                hist_waddr_o,
  output logic [CntW-1:0]                 hist_wdata_o,
  output logic                            hist_clr_o,
  output logic                            cnt_we_o,
  output logic [RIdxW-1:0]                cnt_waddr_o,
  output logic [CntW-1:0]                 cnt_wdata_o,
  output logic                            cnt_clr_o,
  output logic [RIdxW-1:0]                ring_mask_o,
  output logic                            has_res_o,
  output lrbe_pkg::res_flags_t            flags_o,
  output logic [lrbe_pkg::AddrW-1:0]      addr_o,
  output logic [lrbe_pkg::RingCountW-1:0] ring_count_o,
  output logic [lrbe_pkg::PprW-1:0]       ppr_o
);

  localparam int RCntW = RIdxW + 1;
  localparam int ColW  = $clog2(MaxColumns + 1);
  localparam int CW2   = CntW + 1;
  localparam int SumW  = RIdxW + ColW + 1;

  logic [RCntW-1:0]          rings_q, rings_d;
  logic [ColW-1:0]           cols_q, cols_d;
  logic [lrbe_pkg::ChanW-1:0] lc_q, lc_d;
  logic [CntW-1:0]           lcnt_q, lcnt_d;
  logic                      ovf_q, ovf_d;

  always_comb begin
    logic              in_hist;
    logic [CntW-1:0]   hn;
    logic [RIdxW-1:0]  v;
    logic              big;
    logic [RCntW-1:0]  rsel;
    logic [CW2-1:0]    c;
    logic [CW2-1:0]    r;
    logic [ColW-1:0]   csel;
    logic              lim;
    logic              no_size;
    logic [RIdxW-1:0]  ring;
    logic [CntW-1:0]   colsw;
    logic              rov;
    logic              cov;
    logic [CntW-1:0]   col;
    logic [CW2-1:0]    nxt;
    logic [SumW-1:0]   sum;

    in_hist = 32'(channel_i) < MaxRings;
    hn = (hist_rd_i < CntW'(MaxColumns + 1)) ? hist_rd_i + CntW'(1) : hist_rd_i;

    for (int i = 0; i < RIdxW; i++) begin
      v[i] = |(lc_q[RIdxW-1:0] >> i);
    end
    big  = 32'(lc_q) >= MaxRings;
    rsel = {1'b0, v} + RCntW'(1);
    lim  = 1'b0;
    if (rsel < RCntW'(lrbe_pkg::MinRings)) begin
      rsel = RCntW'(lrbe_pkg::MinRings);
    end
    if (big) begin
      rsel = RCntW'(MaxRings);
      lim  = 1'b1;
    end
    c = (lcnt_q < CntW'(lrbe_pkg::ColumnStep)) ? CW2'(lrbe_pkg::ColumnStep) : CW2'(lcnt_q);
    r = (c + CW2'(lrbe_pkg::ColumnRound)) & ~CW2'(lrbe_pkg::ColumnRound);
    if (r > CW2'(MaxColumns)) begin
      csel = ColW'(MaxColumns);
      lim  = 1'b1;
    end else begin
      csel = ColW'(r);
    end

    no_size = (rings_q == '0) || (cols_q == '0);
    ring    = channel_i[RIdxW-1:0] & RIdxW'(rings_q - RCntW'(1));
    colsw   = CntW'(cols_q);
    rov     = channel_i >= lrbe_pkg::ChanW'(rings_q);
    cov     = cnt_rd_i >= colsw;
    col     = cov ? cnt_rd_i - colsw : cnt_rd_i;
    nxt     = CW2'(cnt_rd_i) + CW2'(1);
    if (nxt >= CW2'({cols_q, 1'b0})) begin
      nxt = nxt - CW2'(cols_q);
    end
    sum = SumW'(ring * cols_q) + SumW'(col);

    rings_d      = rings_q;
    cols_d       = cols_q;
    lc_d         = lc_q;
    lcnt_d       = lcnt_q;
    ovf_d        = ovf_q;
    hist_we_o    = 1'b0;
    hist_waddr_o = channel_i[RIdxW-1:0];
    hist_wdata_o = hn;
    hist_clr_o   = 1'b0;
    cnt_we_o     = 1'b0;
    cnt_waddr_o  = ring;
    cnt_wdata_o  = CntW'(nxt);
    cnt_clr_o    = 1'b0;
    has_res_o    = 1'b1;
    flags_o      = '{kind: lrbe_pkg::KindPlaced, default: 1'b0};
    addr_o       = '0;
    ring_count_o = '0;
    ppr_o        = '0;

    unique case (func_i)
      lrbe_pkg::FuncEstimate: begin
        has_res_o = 1'b0;
        if (fire_i) begin
          if (channel_i > lc_q) begin
            lc_d = channel_i;
          end
          if (in_hist) begin
            hist_we_o = 1'b1;
            if (hn > lcnt_q) begin
              lcnt_d = hn;
            end
          end
        end
      end
      lrbe_pkg::FuncFinish: begin
        flags_o.kind     = lrbe_pkg::KindSizes;
        flags_o.size_lim = lim;
        ring_count_o     = lrbe_pkg::RingCountW'(rsel);
        ppr_o            = lrbe_pkg::PprW'(csel);
        if (fire_i) begin
          rings_d    = rsel;
          cols_d     = csel;
          lc_d       = '0;
          lcnt_d     = '0;
          ovf_d      = 1'b0;
          hist_clr_o = 1'b1;
          cnt_clr_o  = 1'b1;
        end
      end
      lrbe_pkg::FuncPlace: begin
        if (no_size) begin
          flags_o.ring_ovf = 1'b1;
          flags_o.col_ovf  = 1'b1;
          if (fire_i) begin
            ovf_d = 1'b1;
          end
        end else begin
          flags_o.ring_ovf = rov;
          flags_o.col_ovf  = cov;
          addr_o           = lrbe_pkg::AddrW'(sum);
          if (fire_i) begin
            cnt_we_o = 1'b1;
            if (rov || cov) begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      lrbe_pkg::FuncEndFrame: begin
        flags_o.kind     = lrbe_pkg::KindFrame;
        flags_o.frame_ok = !ovf_q;
        if (fire_i) begin
          ovf_d     = 1'b0;
          cnt_clr_o = 1'b1;
        end
      end
      default: begin
        has_res_o = 1'b0;
      end
    endcase
  end

  // counter table is read at acceptance, so it sees the ring count as updated
  // by the item that leaves this cycle
  assign ring_mask_o = RIdxW'(rings_d - RCntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rings_q <= '0;
      cols_q  <= '0;
      lc_q    <= '0;
      lcnt_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      rings_q <= rings_d;
      cols_q  <= cols_d;
      lc_q    <= lc_d;
      lcnt_q  <= lcnt_d;
      ovf_q   <= ovf_d;
    end
  end

  a_rings_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(rings_q))
    else $error("ring count not a power of two");

  a_sizes_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rings_q == '0) == (cols_q == '0))
    else $error("ring count and points per ring out of step");

  a_counter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (func_i == lrbe_pkg::FuncPlace) && (cols_q != '0)
    |-> (CW2'(cnt_rd_i) < CW2'({cols_q, 1'b0})))
    else $error("column counter beyond twice points per ring");

endmodule

@@ src/lidar_ring_binning_engine_unit.sv @@
// lidar_ring_binning_engine_unit: top level; item register, result register,
// histogram and column counter tables. Uses lrbe_pkg, lrbe_ram, lrbe_step.
//
//  channel  direction  handshake               payload
//  input    in         in_valid_i / in_ready_o func, channel, payload_0..3
//  output   out        out_valid_o/out_ready_i result_kind .. size_limited
//
// One item per cycle sustained while results are taken; an accepted item goes
// into the item register and its result then into the result register, from
// which it is taken. The tables are read at acceptance and the previous
// item's write is bypassed, so the per-ring read-modify-write sets the
// one-cycle rate. Reset clears the table valid bits at once; there is no
// clearing pass. A result not taken holds the item register, and input is
// taken again as soon as the item register moves on.
module lidar_ring_binning_engine_unit #(
  parameter int MaxRings   = lrbe_pkg::MaxRingsDef,
  parameter int MaxColumns = lrbe_pkg::MaxColumnsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      func_i,
  input  logic [lrbe_pkg::ChanW-1:0]      channel_i,
  input  logic [lrbe_pkg::PayW-1:0]       payload_0_i,
  input  logic [lrbe_pkg::PayW-1:0]       payload_1_i,
  input  logic [lrbe_pkg::PayW-1:0]       payload_2_i,
  input  logic [lrbe_pkg::PayW-1:0]       payload_3_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      result_kind_o,
  output logic [lrbe_pkg::AddrW-1:0]      buffer_address_o,
  output logic [lrbe_pkg::PayW-1:0]       out_word_0_o,
  output logic [lrbe_pkg::PayW-1:0]       out_word_1_o,
  output logic [lrbe_pkg::PayW-1:0]       out_word_2_o,
  output logic [lrbe_pkg::PayW-1:0]       out_word_3_o,
  output logic                            ring_excess_o,
  output logic                            column_overflow_o,
  output logic                            frame_ok_o,
  output logic [lrbe_pkg::RingCountW-1:0] ring_count_o,
  output logic [lrbe_pkg::PprW-1:0]       points_per_ring_o,
  output logic                            size_limited_o
);

  localparam int RIdxW = $clog2(MaxRings);
  localparam int CntW  = $clog2(2 * MaxColumns);

  logic                       in_acc;
  logic                       s1_fire;
  logic                       s1_vld_q;
  lrbe_pkg::func_e            s1_func_q;
  logic [lrbe_pkg::ChanW-1:0] s1_chan_q;
  logic [lrbe_pkg::PayW-1:0]  s1_pay_q [lrbe_pkg::NumWords];

  logic                            out_vld_q;
  lrbe_pkg::res_flags_t            out_flags_q;
  logic [lrbe_pkg::AddrW-1:0]      out_addr_q;
  logic [lrbe_pkg::PayW-1:0]       out_word_q [lrbe_pkg::NumWords];
  logic [lrbe_pkg::RingCountW-1:0] out_rc_q;
  logic [lrbe_pkg::PprW-1:0]       out_ppr_q;

  logic                            hist_we, hist_clr, cnt_we, cnt_clr, has_res;
  logic [RIdxW-1:0]                hist_waddr, cnt_waddr, ring_mask;
  logic [CntW-1:0]                 hist_wdata, cnt_wdata, hist_rd, cnt_rd;
  lrbe_pkg::res_flags_t            flags;
  logic [lrbe_pkg::AddrW-1:0]      addr;
  logic [lrbe_pkg::RingCountW-1:0] rc;
  logic [lrbe_pkg::PprW-1:0]       ppr;

  assign s1_fire    = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_fire;
  assign in_acc     = in_valid_i && in_ready_o;

  lrbe_ram #(.Depth(MaxRings), .Width(CntW)) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_acc),
    .raddr_i (channel_i[RIdxW-1:0]),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .clr_i   (hist_clr),
    .rdata_o (hist_rd)
  );

  lrbe_ram #(.Depth(MaxRings), .Width(CntW)) u_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_acc),
    .raddr_i (channel_i[RIdxW-1:0] & ring_mask),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .clr_i   (cnt_clr),
    .rdata_o (cnt_rd)
  );

  lrbe_step #(.MaxRings(MaxRings), .MaxColumns(MaxColumns)) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .func_i       (s1_func_q),
    .channel_i    (s1_chan_q),
    .hist_rd_i    (hist_rd),
    .cnt_rd_i     (cnt_rd),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .hist_wdata_o (hist_wdata),
    .hist_clr_o   (hist_clr),
    .cnt_we_o     (cnt_we),
    .cnt_waddr_o  (cnt_waddr),
    .cnt_wdata_o  (cnt_wdata),
    .cnt_clr_o    (cnt_clr),
    .ring_mask_o  (ring_mask),
    .has_res_o    (has_res),
    .flags_o      (flags),
    .addr_o       (addr),
    .ring_count_o (rc),
    .ppr_o        (ppr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_q <= has_res;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q   <= lrbe_pkg::func_e'(func_i);
      s1_chan_q   <= channel_i;
      s1_pay_q[0] <= payload_0_i;
      s1_pay_q[1] <= payload_1_i;
      s1_pay_q[2] <= payload_2_i;
      s1_pay_q[3] <= payload_3_i;
    end
    if (s1_fire) begin
      out_flags_q <= flags;
      out_addr_q  <= addr;
      out_rc_q    <= rc;
      out_ppr_q   <= ppr;
      for (int k = 0; k < lrbe_pkg::NumWords; k++) begin
        out_word_q[k] <= (flags.kind == lrbe_pkg::KindPlaced) ? s1_pay_q[k] : '0;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign result_kind_o     = out_flags_q.kind;
  assign buffer_address_o  = out_addr_q;
  assign out_word_0_o      = out_word_q[0];
  assign out_word_1_o      = out_word_q[1];
  assign out_word_2_o      = out_word_q[2];
  assign out_word_3_o      = out_word_q[3];
  assign ring_excess_o     = out_flags_q.ring_ovf;
  assign column_overflow_o = out_flags_q.col_ovf;
  assign frame_ok_o        = out_flags_q.frame_ok;
  assign ring_count_o      = out_rc_q;
  assign points_per_ring_o = out_ppr_q;
  assign size_limited_o    = out_flags_q.size_lim;

  a_res_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_fire))
    else $error("result without a finished item");

  a_nonplaced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_flags_q.kind != lrbe_pkg::KindPlaced)
    |-> (out_addr_q == '0) && (out_word_q[0] == '0) && !out_flags_q.ring_ovf)
    else $error("placement fields set on a non-placement result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i
    |=> out_vld_q && $stable(out_flags_q) && $stable(out_addr_q))
    else $error("waiting result changed");

endmodule

@@ bench/lidar_ring_binning_engine_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for lidar_ring_binning_engine_unit: directed and random items on
// valid/ready channels, checked against a ring binning predictor held in the bench.
// Depends on lrbe_pkg and the engine top level.
module lidar_ring_binning_engine_unit_tb;

  localparam int HistSat = lrbe_pkg::MaxColumnsDef + 1;

  typedef struct packed {
    lrbe_pkg::kind_e                 kind;
    logic [lrbe_pkg::AddrW-1:0]      addr;
    logic [lrbe_pkg::PayW-1:0]       w0;
    logic [lrbe_pkg::PayW-1:0]       w1;
    logic [lrbe_pkg::PayW-1:0]       w2;
    logic [lrbe_pkg::PayW-1:0]       w3;
    logic                            ring_ovf;
    logic                            col_ovf;
    logic                            frame_ok;
    logic [lrbe_pkg::RingCountW-1:0] ring_count;
    logic [lrbe_pkg::PprW-1:0]       ppr;
    logic                            size_lim;
  } binned_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      func = 2'd0;
  logic [lrbe_pkg::ChanW-1:0]      channel = '0;
  logic [lrbe_pkg::PayW-1:0]       pay0 = '0;
  logic [lrbe_pkg::PayW-1:0]       pay1 = '0;
  logic [lrbe_pkg::PayW-1:0]       pay2 = '0;
  logic [lrbe_pkg::PayW-1:0]       pay3 = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      result_kind;
  logic [lrbe_pkg::AddrW-1:0]      buffer_address;
  logic [lrbe_pkg::PayW-1:0]       out_word_0;
  logic [lrbe_pkg::PayW-1:0]       out_word_1;
  logic [lrbe_pkg::PayW-1:0]       out_word_2;
  logic [lrbe_pkg::PayW-1:0]       out_word_3;
  logic                            ring_excess;
  logic                            column_overflow;
  logic                            frame_ok;
  logic [lrbe_pkg::RingCountW-1:0] ring_count;
  logic [lrbe_pkg::PprW-1:0]       points_per_ring;
  logic                            size_limited;

  // bench copy of the binning state
  int unsigned rings_used;
  int unsigned cols_used;
  int unsigned col_cnt [lrbe_pkg::MaxRingsDef];
  int unsigned ring_hist [lrbe_pkg::MaxRingsDef];
  int unsigned top_channel;
  int unsigned top_count;
  bit          ovf_seen;

  binned_result_t pending_results [$];
  int             errors;
  int             items_sent;
  bit             no_idle;

  lidar_ring_binning_engine_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .func_i            (func),
    .channel_i         (channel),
    .payload_0_i       (pay0),
    .payload_1_i       (pay1),
    .payload_2_i       (pay2),
    .payload_3_i       (pay3),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .result_kind_o     (result_kind),
    .buffer_address_o  (buffer_address),
    .out_word_0_o      (out_word_0),
    .out_word_1_o      (out_word_1),
    .out_word_2_o      (out_word_2),
    .out_word_3_o      (out_word_3),
    .ring_excess_o     (ring_excess),
    .column_overflow_o (column_overflow),
    .frame_ok_o        (frame_ok),
    .ring_count_o      (ring_count),
    .points_per_ring_o (points_per_ring),
    .size_limited_o    (size_limited)
  );

  always #1 clk = ~clk;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [lrbe_pkg::PayW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void clear_columns();
    for (int i = 0; i < lrbe_pkg::MaxRingsDef; i++) col_cnt[i] = 0;
    ovf_seen = 1'b0;
  endfunction

  task automatic predict_binning(input lrbe_pkg::func_e f,
                                 input logic [lrbe_pkg::ChanW-1:0] ch,
                                 input logic [lrbe_pkg::PayW-1:0] p0, p1, p2, p3);
    binned_result_t r;
    int unsigned    rings;
    int unsigned    cols;
    int unsigned    ring;
    int unsigned    raw;
    int unsigned    nxt;
    r = '0;
    case (f)
      lrbe_pkg::FuncEstimate: begin
        if (ch > top_channel) top_channel = 32'(ch);
        if (ch < lrbe_pkg::MaxRingsDef) begin
          if (ring_hist[ch] < HistSat) ring_hist[ch]++;
          if (ring_hist[ch] > top_count) top_count = ring_hist[ch];
        end
      end
      lrbe_pkg::FuncFinish: begin
        rings = lrbe_pkg::MinRings;
        while (rings <= top_channel) rings = rings << 1;
        if (rings > lrbe_pkg::MaxRingsDef) begin
          rings = lrbe_pkg::MaxRingsDef;
          r.size_lim = 1'b1;
        end
        cols = (top_count < lrbe_pkg::ColumnStep) ? lrbe_pkg::ColumnStep : top_count;
        cols = (cols + lrbe_pkg::ColumnRound) / lrbe_pkg::ColumnStep * lrbe_pkg::ColumnStep;
        if (cols > lrbe_pkg::MaxColumnsDef) begin
          cols = lrbe_pkg::MaxColumnsDef;
          r.size_lim = 1'b1;
        end
        rings_used = rings;
        cols_used = cols;
        for (int i = 0; i < lrbe_pkg::MaxRingsDef; i++) ring_hist[i] = 0;
        top_channel = 0;
        top_count = 0;
        clear_columns();
        r.kind = lrbe_pkg::KindSizes;
        r.ring_count = rings[lrbe_pkg::RingCountW-1:0];
        r.ppr = cols[lrbe_pkg::PprW-1:0];
        pending_results.push_back(r);
      end
      lrbe_pkg::FuncPlace: begin
        r.kind = lrbe_pkg::KindPlaced;
        r.w0 = p0;
        r.w1 = p1;
        r.w2 = p2;
        r.w3 = p3;
        if (rings_used == 0 || cols_used == 0) begin
          r.ring_ovf = 1'b1;
          r.col_ovf = 1'b1;
          ovf_seen = 1'b1;
        end else begin
          ring = ch & (rings_used - 1) & (lrbe_pkg::MaxRingsDef - 1);
          raw = col_cnt[ring];
          r.ring_ovf = (ch >= rings_used);
          r.col_ovf = (raw >= cols_used);
          nxt = raw + 1;
          if (nxt >= 2 * cols_used) nxt = nxt - cols_used;
          col_cnt[ring] = nxt;
          if (r.ring_ovf || r.col_ovf) ovf_seen = 1'b1;
          r.addr = lrbe_pkg::AddrW'(ring * cols_used + raw % cols_used);
        end
        pending_results.push_back(r);
      end
      default: begin
        r.kind = lrbe_pkg::KindFrame;
        r.frame_ok = !ovf_seen;
        clear_columns();
        pending_results.push_back(r);
      end
    endcase
  endtask

  task automatic send_item(input lrbe_pkg::func_e f, input logic [lrbe_pkg::ChanW-1:0] ch,
                           input logic [lrbe_pkg::PayW-1:0] p0, p1, p2, p3);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    channel <= ch;
    pay0 <= p0;
    pay1 <= p1;
    pay2 <= p2;
    pay3 <= p3;
    do @(posedge clk); while (!in_ready);
    predict_binning(f, ch, p0, p1, p2, p3);
    items_sent++;
  endtask

  task automatic send_random(input lrbe_pkg::func_e f, input logic [lrbe_pkg::ChanW-1:0] ch);
    send_item(f, ch, rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v, got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  initial begin : result_checker
    binned_result_t want;
    int             stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t result_kind: expected none, got %0h", $time, result_kind);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.kind, result_kind);
        check_field("buffer_address", want.addr, buffer_address);
        check_field("out_word_0", want.w0, out_word_0);
        check_field("out_word_1", want.w1, out_word_1);
        check_field("out_word_2", want.w2, out_word_2);
        check_field("out_word_3", want.w3, out_word_3);
        check_field("ring_excess", want.ring_ovf, ring_excess);
        check_field("column_overflow", want.col_ovf, column_overflow);
        check_field("frame_ok", want.frame_ok, frame_ok);
        check_field("ring_count", want.ring_count, ring_count);
        check_field("points_per_ring", want.ppr, points_per_ring);
        check_field("size_limited", want.size_lim, size_limited);
      end
    end
  end

  task automatic test_directed();
    logic [lrbe_pkg::PayW-1:0] ones;
    logic [lrbe_pkg::PayW-1:0] alt;
    ones = '1;
    alt = 64'haaaa_aaaa_aaaa_aaaa;
    // placing before any estimate
    send_item(lrbe_pkg::FuncPlace, 16'd5, ones, ones, ones, ones);
    send_item(lrbe_pkg::FuncEndFrame, 16'd0, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncEndFrame, 16'hffff, '0, '0, '0, '0);
    // empty estimate gives the minimum sizes
    send_item(lrbe_pkg::FuncFinish, 16'd0, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncPlace, 16'd0, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncPlace, 16'd16, alt, ~alt, alt, ~alt);
    send_item(lrbe_pkg::FuncPlace, 16'hffff, ~alt, alt, ~alt, alt);
    send_item(lrbe_pkg::FuncEndFrame, 16'd0, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncPlace, 16'd15, ones, '0, ones, '0);
    send_item(lrbe_pkg::FuncEndFrame, 16'd0, '0, '0, '0, '0);
    drain_results();
    // channels beyond the histogram cap the ring count
    send_item(lrbe_pkg::FuncEstimate, 16'd0, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncEstimate, 16'd127, ones, ones, ones, ones);
    send_item(lrbe_pkg::FuncEstimate, 16'd128, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncEstimate, 16'hffff, ones, ones, ones, ones);
    send_item(lrbe_pkg::FuncFinish, 16'hffff, ones, ones, ones, ones);
    send_item(lrbe_pkg::FuncPlace, 16'd127, ones, ones, ones, ones);
    send_item(lrbe_pkg::FuncPlace, 16'd128, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncEstimate, 16'd63, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncEstimate, 16'd63, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncFinish, 16'd0, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncFinish, 16'd0, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncEstimate, 16'd16, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncFinish, 16'd0, '0, '0, '0, '0);
    send_item(lrbe_pkg::FuncEndFrame, 16'd0, '0, '0, '0, '0);
  endtask

  // a count just above one column step rounds up to the next step
  task automatic test_count_rounding();
    no_idle = 1'b1;
    repeat (520) send_random(lrbe_pkg::FuncEstimate, 16'd100);
    send_random(lrbe_pkg::FuncEstimate, 16'd9);
    no_idle = 1'b0;
    send_random(lrbe_pkg::FuncFinish, 16'd0);
    send_random(lrbe_pkg::FuncPlace, 16'd127);
    send_random(lrbe_pkg::FuncPlace, 16'd100);
    send_random(lrbe_pkg::FuncPlace, 16'd100);
    send_random(lrbe_pkg::FuncEndFrame, 16'd0);
  endtask

  // one ring past points per ring and on through the counter wrap
  task automatic test_column_wrap();
    logic [lrbe_pkg::ChanW-1:0] ch;
    send_random(lrbe_pkg::FuncFinish, 16'd3);
    for (int i = 0; i < 1050; i++) begin
      no_idle = (i < 600);
      ch = ($urandom_range(0, 7) == 0) ?
           lrbe_pkg::ChanW'(3 + 16 * $urandom_range(0, 4095)) : 16'd3;
      send_random(lrbe_pkg::FuncPlace, ch);
    end
    send_random(lrbe_pkg::FuncEndFrame, 16'd0);
    send_random(lrbe_pkg::FuncPlace, 16'd3);
    send_random(lrbe_pkg::FuncEndFrame, 16'd0);
  endtask

  task automatic test_random_frames();
    int                         start;
    int                         maxch;
    logic [lrbe_pkg::ChanW-1:0] heavy;
    logic [lrbe_pkg::ChanW-1:0] ch;
    start = items_sent;
    while (items_sent - start < 350) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_random(lrbe_pkg::func_e'($urandom_range(0, 3)), lrbe_pkg::ChanW'($urandom));
        end
      end else begin
        case ($urandom_range(0, 4))
          0: maxch = 15;
          1: maxch = 31;
          2: maxch = 63;
          3: maxch = 127;
          default: maxch = $urandom_range(0, 65535);
        endcase
        repeat ($urandom_range(0, 30)) begin
          send_random(lrbe_pkg::FuncEstimate, lrbe_pkg::ChanW'($urandom_range(0, maxch)));
        end
        if ($urandom_range(0, 7) == 0) begin
          heavy = lrbe_pkg::ChanW'($urandom_range(0, 127));
          repeat ($urandom_range(513, 640)) send_random(lrbe_pkg::FuncEstimate, heavy);
        end
        send_random(lrbe_pkg::FuncFinish, lrbe_pkg::ChanW'($urandom));
        repeat ($urandom_range(1, 50)) begin
          ch = ($urandom_range(0, 5) == 0) ? lrbe_pkg::ChanW'($urandom) :
               lrbe_pkg::ChanW'($urandom_range(0, maxch));
          send_random(lrbe_pkg::FuncPlace, ch);
        end
        if ($urandom_range(0, 3) != 0) begin
          send_random(lrbe_pkg::FuncEndFrame, lrbe_pkg::ChanW'($urandom));
        end
      end
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_count_rounding();
    test_column_wrap();
    test_random_frames();
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** lidar_ring_binning_engine_unit: PASSED **");
    end else begin
      $display("** lidar_ring_binning_engine_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** lidar_ring_binning_engine_unit: FAILED **");
    $finish;
  end

endmodule
